>>> sv/swb_pkg.sv
// Shared types, constants and helpers of the single-wire bit sniffer.
package swb_pkg;

  localparam int unsigned CounterWidthDef = 16;
  localparam int unsigned SampleDelayW    = 8;
  localparam int unsigned GapLimitW       = 16;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 16;
  localparam int unsigned CharW           = 7;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned BitPosW         = 3;
  localparam int unsigned NibbleW         = 4;

  localparam logic [SampleDelayW-1:0] SampleDelayRst = 8'd4;
  localparam logic [GapLimitW-1:0]    GapLimitRst    = 16'd24;
  localparam logic [CharW-1:0]        NewlineChar    = 7'h0A;
  localparam logic [CharW-1:0]        DigitZeroChar  = 7'h30;
  localparam logic [CharW-1:0]        LetterAChar    = 7'h41;
  localparam logic [BitPosW-1:0]      LastBitPos     = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    RegSampleDelay = 1'b0,
    RegGapLimit    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ChHigh = 2'd0,
    ChLow  = 2'd1,
    ChNewline = 2'd2
  } char_sel_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_push_t;

  function automatic logic [CharW-1:0] hex_ascii(input logic [NibbleW-1:0] nib);
    logic [CharW-1:0] ch;
    if (nib < 4'd10) begin
      ch = DigitZeroChar + CharW'(nib);
    end else begin
      ch = LetterAChar + CharW'(nib - 4'd10);
    end
    return ch;
  endfunction

endpackage

>>> sv/swb_ifs.sv
// Handshake channel interfaces of the single-wire bit sniffer.
interface swb_in_if;
  logic valid;
  logic ready;
  logic line_level;
  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface swb_out_if;
  logic                        valid;
  logic                        ready;
  logic [swb_pkg::CharW-1:0]   hex_char;
  logic                        last_of_byte;
  modport source (output valid, output hex_char, output last_of_byte, input ready);
  modport sink (input valid, input hex_char, input last_of_byte, output ready);
endinterface

interface swb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [swb_pkg::CfgIdxW-1:0]  index;
  logic [swb_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/swb_decode.sv
// Per-tick edge detect, sample delay, gap check and LSB-first byte assembly.
module swb_decode #(
  parameter int unsigned COUNTER_WIDTH = swb_pkg::CounterWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                level_i,
  swb_cfg_if.sink             cfg_i,
  output swb_pkg::byte_push_t push_o
);

  localparam int unsigned CmpW =
    (COUNTER_WIDTH > swb_pkg::GapLimitW) ? COUNTER_WIDTH : swb_pkg::GapLimitW;

  logic [swb_pkg::SampleDelayW-1:0] delay_cfg_q;
  logic [swb_pkg::GapLimitW-1:0]    gap_cfg_q;
  logic                             prev_q, prev_d;
  logic [swb_pkg::SampleDelayW-1:0] cnt_q, cnt_d;
  logic [COUNTER_WIDTH-1:0]         since_q, since_d, since_inc;
  logic [swb_pkg::ByteW-1:0]        bits_q, bits_d, bits_new;
  logic [swb_pkg::BitPosW-1:0]      pos_q, pos_d, pos_base;
  logic                             restart;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_cfg_q <= swb_pkg::SampleDelayRst;
      gap_cfg_q   <= swb_pkg::GapLimitRst;
    end else if (cfg_i.valid) begin
      unique case (swb_pkg::cfg_reg_e'(cfg_i.index))
        swb_pkg::RegSampleDelay: delay_cfg_q <= cfg_i.data[swb_pkg::SampleDelayW-1:0];
        swb_pkg::RegGapLimit:    gap_cfg_q   <= cfg_i.data[swb_pkg::GapLimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    since_inc = (since_q != '1) ? since_q + 1'b1 : since_q;
    restart   = CmpW'(since_inc) > CmpW'(gap_cfg_q);
    pos_base  = restart ? '0 : pos_q;
    bits_new  = restart ? '0 : bits_q;
    bits_new[pos_base] = level_i;

    prev_d        = prev_q;
    cnt_d         = cnt_q;
    since_d       = since_inc;
    bits_d        = bits_q;
    pos_d         = pos_q;
    push_o.valid  = 1'b0;
    push_o.data   = bits_new;

    if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == swb_pkg::SampleDelayW'(1)) begin
        since_d = '0;
        if (pos_base == swb_pkg::LastBitPos) begin
          push_o.valid = tick_i;
          bits_d       = '0;
          pos_d        = '0;
        end else begin
          bits_d = bits_new;
          pos_d  = pos_base + 1'b1;
        end
      end
    end else begin
      if (prev_q && !level_i) begin
        cnt_d = (delay_cfg_q == '0) ? swb_pkg::SampleDelayW'(1) : delay_cfg_q;
      end
      prev_d = level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      cnt_q   <= '0;
      since_q <= '0;
      bits_q  <= '0;
      pos_q   <= '0;
    end else if (tick_i) begin
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      since_q <= since_d;
      bits_q  <= bits_d;
      pos_q   <= pos_d;
    end
  end

endmodule

>>> sv/swb_hexser.sv
// Two-deep byte buffer that sends each byte as two hex digits and a newline.
module swb_hexser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swb_pkg::byte_push_t push_i,
  output logic                full_o,
  swb_out_if.source           out_o
);

  logic                      cur_valid_q, cur_valid_d;
  logic [swb_pkg::ByteW-1:0] cur_byte_q, cur_byte_d;
  swb_pkg::char_sel_e        sel_q, sel_d;
  logic                      nxt_valid_q, nxt_valid_d;
  logic [swb_pkg::ByteW-1:0] nxt_byte_q, nxt_byte_d;
  logic                      out_fire, done;

  assign full_o   = nxt_valid_q;
  assign out_fire = out_o.valid && out_o.ready;
  assign done     = out_fire && (sel_q == swb_pkg::ChNewline);

  assign out_o.valid = cur_valid_q;

  always_comb begin
    out_o.last_of_byte = 1'b0;
    unique case (sel_q)
      swb_pkg::ChHigh:    out_o.hex_char = swb_pkg::hex_ascii(cur_byte_q[7:4]);
      swb_pkg::ChLow:     out_o.hex_char = swb_pkg::hex_ascii(cur_byte_q[3:0]);
      swb_pkg::ChNewline: begin
        out_o.hex_char     = swb_pkg::NewlineChar;
        out_o.last_of_byte = 1'b1;
      end
      default: out_o.hex_char = swb_pkg::NewlineChar;
    endcase
  end

  always_comb begin
    cur_valid_d = cur_valid_q && !done;
    cur_byte_d  = cur_byte_q;
    nxt_valid_d = nxt_valid_q;
    nxt_byte_d  = nxt_byte_q;
    sel_d       = sel_q;
    if (out_fire) begin
      unique case (sel_q)
        swb_pkg::ChHigh: sel_d = swb_pkg::ChLow;
        swb_pkg::ChLow:  sel_d = swb_pkg::ChNewline;
        default:         sel_d = swb_pkg::ChHigh;
      endcase
    end
    if (!cur_valid_d && nxt_valid_q) begin
      cur_valid_d = 1'b1;
      cur_byte_d  = nxt_byte_q;
      nxt_valid_d = 1'b0;
      sel_d       = swb_pkg::ChHigh;
    end
    if (push_i.valid) begin
      if (!cur_valid_d) begin
        cur_valid_d = 1'b1;
        cur_byte_d  = push_i.data;
        sel_d       = swb_pkg::ChHigh;
      end else begin
        nxt_valid_d = 1'b1;
        nxt_byte_d  = push_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      nxt_valid_q <= 1'b0;
      sel_q       <= swb_pkg::ChHigh;
    end else begin
      cur_valid_q <= cur_valid_d;
      nxt_valid_q <= nxt_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_byte_q <= cur_byte_d;
    nxt_byte_q <= nxt_byte_d;
  end

  a_nxt_implies_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nxt_valid_q |-> cur_valid_q)
    else $error("queued byte without a byte in transmission");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !nxt_valid_q)
    else $error("byte pushed into a full buffer");

  a_promote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && nxt_valid_q |=> cur_valid_q && sel_q == swb_pkg::ChHigh)
    else $error("queued byte not promoted after newline transfer");

  a_hold_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !out_fire |=> sel_q == $past(sel_q))
    else $error("character select moved without a transfer");

endmodule

>>> sv/single_wire_bit_sniffer_hex.sv
// Single-wire bit sniffer: one line sample per cycle in, hex text per byte out.
// Each accepted input item is one timer tick of line level. A falling edge
// starts a countdown of sample_delay ticks (0 acts as 1); when it expires the
// line is taken as the next data bit, LSB first, and a byte is restarted if
// more than gap_limit ticks passed since the previous sample. Every eighth
// bit yields three output transfers: high hex digit, low hex digit, newline
// (last_of_byte set). The block accepts one tick every cycle while input ready
// is high; a tick is processed in the cycle it is accepted. Finished bytes go
// into a two-entry buffer in front of the character output, and input ready
// drops only while both entries are held. Config writes are taken at any
// cycle (ready is always high); index 0 is sample_delay, index 1 gap_limit.
module single_wire_bit_sniffer_hex #(
  parameter int unsigned COUNTER_WIDTH = swb_pkg::CounterWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swb_in_if.sink     in_i,
  swb_cfg_if.sink    cfg_i,
  swb_out_if.source  out_o
);

  swb_pkg::byte_push_t push;
  logic                buf_full;
  logic                tick;

  assign in_i.ready = !buf_full;
  assign tick       = in_i.valid && !buf_full;

  swb_decode #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .level_i (in_i.line_level),
    .cfg_i   (cfg_i),
    .push_o  (push)
  );

  swb_hexser u_hexser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (buf_full),
    .out_o  (out_o)
  );

endmodule
